### hw/rtl/owm_pkg.sv
// Package for the single-wire bus master: opcodes, bus phases, register
// indexes, ROM command bytes and the types shared between the core and top.
// No dependencies.
`default_nettype none

package owm_pkg;

   localparam int CFG_W           = 10;
   localparam int CFG_COUNT       = 8;
   localparam int CFG_IDX_W       = 3;
   localparam int TIMER_WIDTH_DEF = 10;

   typedef enum logic [2:0] {
      OP_TICK      = 3'd0,
      OP_BUS_RESET = 3'd1,
      OP_WRITE     = 3'd2,
      OP_READ      = 3'd3,
      OP_CONVERT   = 3'd4,
      OP_READ_TEMP = 3'd5
   } op_type;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_RST_LOW  = 4'd1,
      PH_RST_WAIT = 4'd2,
      PH_RST_TAIL = 4'd3,
      PH_WR_START = 4'd4,
      PH_WR_HOLD  = 4'd5,
      PH_WR_REC   = 4'd6,
      PH_RD_START = 4'd7,
      PH_RD_WAIT  = 4'd8,
      PH_RD_REC   = 4'd9
   } phase_type;

   // Timing register indexes.
   localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
   localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
   localparam logic [CFG_IDX_W-1:0] REG_RESET_TAIL    = 3'd2;
   localparam logic [CFG_IDX_W-1:0] REG_SLOT_START    = 3'd3;
   localparam logic [CFG_IDX_W-1:0] REG_WRITE_HOLD    = 3'd4;
   localparam logic [CFG_IDX_W-1:0] REG_WRITE_REC     = 3'd5;
   localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE   = 3'd6;
   localparam logic [CFG_IDX_W-1:0] REG_READ_REC      = 3'd7;

   localparam logic [CFG_W-1:0] RST_RESET_LOW     = 10'd490;
   localparam logic [CFG_W-1:0] RST_PRESENCE_WAIT = 10'd68;
   localparam logic [CFG_W-1:0] RST_RESET_TAIL    = 10'd423;
   localparam logic [CFG_W-1:0] RST_SLOT_START    = 10'd2;
   localparam logic [CFG_W-1:0] RST_WRITE_HOLD    = 10'd62;
   localparam logic [CFG_W-1:0] RST_WRITE_REC     = 10'd2;
   localparam logic [CFG_W-1:0] RST_READ_SAMPLE   = 10'd4;
   localparam logic [CFG_W-1:0] RST_READ_REC      = 10'd62;

   // ROM and function command bytes.
   localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
   localparam logic [7:0] CMD_CONVERT    = 8'h44;
   localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;

   // Sequence step at which each element starts.
   localparam logic [2:0] STEP_FIRST_BYTE  = 3'd1;
   localparam logic [2:0] STEP_SECOND_BYTE = 3'd2;
   localparam logic [2:0] STEP_LOW_BYTE    = 3'd3;
   localparam logic [2:0] STEP_HIGH_BYTE   = 3'd4;
   localparam logic [2:0] LAST_BIT         = 3'd7;

   typedef logic [CFG_COUNT-1:0][CFG_W-1:0] cfg_bank_type;

   typedef struct packed {
      logic        pull_low;
      logic        busy_res;
      logic        accepted;
      logic        done_res;
      logic        present;
      logic [7:0]  read_byte;
      logic [15:0] temperature_raw;
   } result_type;

endpackage

`default_nettype wire

### hw/rtl/owm_if.sv
// Channel interfaces of the single-wire bus master: command/tick requests,
// results and timing register writes. Depends on owm_pkg.
`default_nettype none

interface owm_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] op;
   logic [7:0] write_byte;
   logic       line_level;

   modport source (output valid, output op, output write_byte, output line_level,
                   input ready);
   modport sink   (input valid, input op, input write_byte, input line_level,
                   output ready);
endinterface

interface owm_rsp_if;
   logic        valid;
   logic        ready;
   logic        pull_low;
   logic        busy_res;
   logic        accepted;
   logic        done_res;
   logic        present;
   logic [7:0]  read_byte;
   logic [15:0] temperature_raw;

   modport source (output valid, output pull_low, output busy_res, output accepted,
                   output done_res, output present, output read_byte,
                   output temperature_raw, input ready);
   modport sink   (input valid, input pull_low, input busy_res, input accepted,
                   input done_res, input present, input read_byte,
                   input temperature_raw, output ready);
endinterface

interface owm_csr_if;
   logic                           valid;
   logic                           ready;
   logic [owm_pkg::CFG_IDX_W-1:0]  index;
   logic [owm_pkg::CFG_W-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/owm_core.sv
// Bus sequencer of the single-wire master: phase, slot timer, bit and
// sequence counters, shift register and received data.
// Depends on owm_pkg.
`default_nettype none

module owm_core #(
   parameter int TIMER_WIDTH = owm_pkg::TIMER_WIDTH_DEF
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    step,
   input  wire [2:0]              op,
   input  wire [7:0]              write_byte,
   input  wire                    line_level,
   input  owm_pkg::cfg_bank_type  cfg,
   output owm_pkg::result_type    result
);

   localparam int XW = (TIMER_WIDTH > owm_pkg::CFG_W) ? TIMER_WIDTH : owm_pkg::CFG_W;

   owm_pkg::phase_type      phase_ff, phase_in;
   logic [TIMER_WIDTH-1:0]  time_left_ff, time_left_in;
   logic [2:0]              bit_index_ff, bit_index_in;
   logic [2:0]              seq_step_ff, seq_step_in;
   logic [2:0]              cur_cmd_ff, cur_cmd_in;
   logic [7:0]              shift_ff, shift_in;
   logic [15:0]             temp_ff, temp_in;
   logic                    pres_ff, pres_in;
   logic [7:0]              rcv_ff, rcv_in;

   logic                              load;
   logic [owm_pkg::CFG_IDX_W-1:0]     load_idx;
   logic                              elem_done;
   logic                              done;
   logic                              acc;

   // A register value of zero counts as one, and values beyond the timer saturate.
   function automatic logic [TIMER_WIDTH-1:0] clamp_time(input logic [owm_pkg::CFG_W-1:0] v);
      logic [XW-1:0] ext;
      logic [XW-1:0] tmax;
      ext  = XW'(v);
      tmax = XW'({TIMER_WIDTH{1'b1}});
      if (ext == '0) begin
         ext = XW'(1);
      end else if (ext > tmax) begin
         ext = tmax;
      end
      return ext[TIMER_WIDTH-1:0];
   endfunction

   // Next state.
   always_comb begin
      phase_in     = phase_ff;
      time_left_in = time_left_ff;
      bit_index_in = bit_index_ff;
      seq_step_in  = seq_step_ff;
      cur_cmd_in   = cur_cmd_ff;
      shift_in     = shift_ff;
      temp_in      = temp_ff;
      pres_in      = pres_ff;
      rcv_in       = rcv_ff;
      load         = 1'b0;
      load_idx     = owm_pkg::REG_SLOT_START;
      elem_done    = 1'b0;
      done         = 1'b0;
      acc          = 1'b0;

      case (op)
         owm_pkg::OP_TICK: begin
            if (phase_ff != owm_pkg::PH_IDLE) begin
               if (time_left_ff > TIMER_WIDTH'(1)) begin
                  time_left_in = time_left_ff - TIMER_WIDTH'(1);
               end else begin
                  case (phase_ff)
                     owm_pkg::PH_RST_LOW: begin
                        phase_in = owm_pkg::PH_RST_WAIT;
                        load     = 1'b1;
                        load_idx = owm_pkg::REG_PRESENCE_WAIT;
                     end
                     owm_pkg::PH_RST_WAIT: begin
                        pres_in  = ~line_level;
                        phase_in = owm_pkg::PH_RST_TAIL;
                        load     = 1'b1;
                        load_idx = owm_pkg::REG_RESET_TAIL;
                     end
                     owm_pkg::PH_RST_TAIL: begin
                        elem_done = 1'b1;
                     end
                     owm_pkg::PH_WR_START: begin
                        phase_in = owm_pkg::PH_WR_HOLD;
                        load     = 1'b1;
                        load_idx = owm_pkg::REG_WRITE_HOLD;
                     end
                     owm_pkg::PH_WR_HOLD: begin
                        phase_in = owm_pkg::PH_WR_REC;
                        load     = 1'b1;
                        load_idx = owm_pkg::REG_WRITE_REC;
                     end
                     owm_pkg::PH_WR_REC: begin
                        shift_in = {1'b0, shift_ff[7:1]};
                        if (bit_index_ff == owm_pkg::LAST_BIT) begin
                           elem_done = 1'b1;
                        end else begin
                           bit_index_in = bit_index_ff + 3'd1;
                           phase_in     = owm_pkg::PH_WR_START;
                           load         = 1'b1;
                           load_idx     = owm_pkg::REG_SLOT_START;
                        end
                     end
                     owm_pkg::PH_RD_START: begin
                        phase_in = owm_pkg::PH_RD_WAIT;
                        load     = 1'b1;
                        load_idx = owm_pkg::REG_READ_SAMPLE;
                     end
                     owm_pkg::PH_RD_WAIT: begin
                        shift_in = {line_level, shift_ff[7:1]};
                        phase_in = owm_pkg::PH_RD_REC;
                        load     = 1'b1;
                        load_idx = owm_pkg::REG_READ_REC;
                     end
                     owm_pkg::PH_RD_REC: begin
                        if (bit_index_ff == owm_pkg::LAST_BIT) begin
                           // The high byte lands above the low byte received just before.
                           if (cur_cmd_ff == owm_pkg::OP_READ_TEMP &&
                               seq_step_ff == owm_pkg::STEP_HIGH_BYTE) begin
                              temp_in = {shift_ff, rcv_ff};
                           end
                           rcv_in    = shift_ff;
                           elem_done = 1'b1;
                        end else begin
                           bit_index_in = bit_index_ff + 3'd1;
                           phase_in     = owm_pkg::PH_RD_START;
                           load         = 1'b1;
                           load_idx     = owm_pkg::REG_SLOT_START;
                        end
                     end
                     default: begin
                        phase_in     = owm_pkg::PH_IDLE;
                        time_left_in = '0;
                     end
                  endcase
               end
            end
         end
         owm_pkg::OP_BUS_RESET, owm_pkg::OP_WRITE, owm_pkg::OP_READ,
         owm_pkg::OP_CONVERT, owm_pkg::OP_READ_TEMP: begin
            if (phase_ff == owm_pkg::PH_IDLE) begin
               acc         = 1'b1;
               cur_cmd_in  = op;
               seq_step_in = '0;
               load        = 1'b1;
               if (op == owm_pkg::OP_WRITE) begin
                  shift_in     = write_byte;
                  bit_index_in = '0;
                  phase_in     = owm_pkg::PH_WR_START;
                  load_idx     = owm_pkg::REG_SLOT_START;
               end else if (op == owm_pkg::OP_READ) begin
                  shift_in     = '0;
                  bit_index_in = '0;
                  phase_in     = owm_pkg::PH_RD_START;
                  load_idx     = owm_pkg::REG_SLOT_START;
               end else begin
                  phase_in = owm_pkg::PH_RST_LOW;
                  load_idx = owm_pkg::REG_RESET_LOW;
               end
            end
         end
         default: begin
         end
      endcase

      // A reset or byte has finished: start the next element of a sequence or stop.
      if (elem_done) begin
         seq_step_in  = seq_step_ff + 3'd1;
         bit_index_in = '0;
         if (cur_cmd_ff == owm_pkg::OP_CONVERT &&
             ((seq_step_in == owm_pkg::STEP_FIRST_BYTE && pres_ff) ||
              seq_step_in == owm_pkg::STEP_SECOND_BYTE)) begin
            shift_in = (seq_step_in == owm_pkg::STEP_FIRST_BYTE) ?
                       owm_pkg::CMD_SKIP_ROM : owm_pkg::CMD_CONVERT;
            phase_in = owm_pkg::PH_WR_START;
            load     = 1'b1;
            load_idx = owm_pkg::REG_SLOT_START;
         end else if (cur_cmd_ff == owm_pkg::OP_READ_TEMP &&
                      ((seq_step_in == owm_pkg::STEP_FIRST_BYTE && pres_ff) ||
                       seq_step_in == owm_pkg::STEP_SECOND_BYTE)) begin
            shift_in = (seq_step_in == owm_pkg::STEP_FIRST_BYTE) ?
                       owm_pkg::CMD_SKIP_ROM : owm_pkg::CMD_READ_SCRATCH;
            phase_in = owm_pkg::PH_WR_START;
            load     = 1'b1;
            load_idx = owm_pkg::REG_SLOT_START;
         end else if (cur_cmd_ff == owm_pkg::OP_READ_TEMP &&
                      (seq_step_in == owm_pkg::STEP_LOW_BYTE ||
                       seq_step_in == owm_pkg::STEP_HIGH_BYTE)) begin
            shift_in = '0;
            phase_in = owm_pkg::PH_RD_START;
            load     = 1'b1;
            load_idx = owm_pkg::REG_SLOT_START;
         end else begin
            // With no device on the bus the temperature reading is cleared.
            if (cur_cmd_ff == owm_pkg::OP_READ_TEMP &&
                seq_step_in == owm_pkg::STEP_FIRST_BYTE) begin
               temp_in = '0;
            end
            bit_index_in = bit_index_ff;
            phase_in     = owm_pkg::PH_IDLE;
            time_left_in = '0;
            done         = 1'b1;
         end
      end

      if (load) begin
         time_left_in = clamp_time(cfg[load_idx]);
      end
   end

   // Result fields follow the state after the item.
   always_comb begin
      result.pull_low = 1'b0;
      case (phase_in)
         owm_pkg::PH_RST_LOW, owm_pkg::PH_WR_START, owm_pkg::PH_RD_START: begin
            result.pull_low = 1'b1;
         end
         owm_pkg::PH_WR_HOLD: begin
            result.pull_low = ~shift_in[0];
         end
         default: begin
            result.pull_low = 1'b0;
         end
      endcase
      result.busy_res        = (phase_in != owm_pkg::PH_IDLE);
      result.accepted        = acc;
      result.done_res        = done;
      result.present         = pres_in;
      result.read_byte       = rcv_in;
      result.temperature_raw = temp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= owm_pkg::PH_IDLE;
         time_left_ff <= '0;
         bit_index_ff <= '0;
         seq_step_ff  <= '0;
         cur_cmd_ff   <= '0;
         shift_ff     <= '0;
         temp_ff      <= '0;
         pres_ff      <= 1'b0;
         rcv_ff       <= '0;
      end else if (step) begin
         phase_ff     <= phase_in;
         time_left_ff <= time_left_in;
         bit_index_ff <= bit_index_in;
         seq_step_ff  <= seq_step_in;
         cur_cmd_ff   <= cur_cmd_in;
         shift_ff     <= shift_in;
         temp_ff      <= temp_in;
         pres_ff      <= pres_in;
         rcv_ff       <= rcv_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/one_wire_master_temp_reader_top.sv
// Top level of the single-wire bus master with temperature read sequences.
// Depends on owm_pkg, the channel interfaces in owm_if and owm_core.
//
//   channel   direction   transfer carries
//   req_if    in          op, write_byte, line_level
//   rsp_if    out         pull_low, busy_res, accepted, done_res, present,
//                         read_byte, temperature_raw
//   csr_if    in          index, data (timing register write)
//
// Every request yields one result in the cycle after its transfer; a request
// can be taken every cycle while no result stalls, the rate being set by the
// single result register. The result register frees up in the same cycle its
// result is taken, so a stalled result holds off requests only while it waits.
// Synchronous reset restores the default timings and leaves the bus idle.
`default_nettype none

module one_wire_master_temp_reader_top #(
   parameter int TIMER_WIDTH = owm_pkg::TIMER_WIDTH_DEF
) (
   input wire          clock,
   input wire          reset,
   owm_req_if.sink     req_if,
   owm_rsp_if.source   rsp_if,
   owm_csr_if.sink     csr_if
);

   owm_pkg::cfg_bank_type  cfg_ff;
   owm_pkg::result_type    result;
   owm_pkg::result_type    rsp_data_ff;
   logic                   rsp_valid_ff;
   logic                   req_take;

   assign req_if.ready = ~rsp_valid_ff | rsp_if.ready;
   assign req_take     = req_if.valid & req_if.ready;
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[owm_pkg::REG_RESET_LOW]     <= owm_pkg::RST_RESET_LOW;
         cfg_ff[owm_pkg::REG_PRESENCE_WAIT] <= owm_pkg::RST_PRESENCE_WAIT;
         cfg_ff[owm_pkg::REG_RESET_TAIL]    <= owm_pkg::RST_RESET_TAIL;
         cfg_ff[owm_pkg::REG_SLOT_START]    <= owm_pkg::RST_SLOT_START;
         cfg_ff[owm_pkg::REG_WRITE_HOLD]    <= owm_pkg::RST_WRITE_HOLD;
         cfg_ff[owm_pkg::REG_WRITE_REC]     <= owm_pkg::RST_WRITE_REC;
         cfg_ff[owm_pkg::REG_READ_SAMPLE]   <= owm_pkg::RST_READ_SAMPLE;
         cfg_ff[owm_pkg::REG_READ_REC]      <= owm_pkg::RST_READ_REC;
      end else if (csr_if.valid) begin
         cfg_ff[csr_if.index] <= csr_if.data;
      end
   end

   owm_core #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (req_take),
      .op         (req_if.op),
      .write_byte (req_if.write_byte),
      .line_level (req_if.line_level),
      .cfg        (cfg_ff),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         rsp_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.pull_low        = rsp_data_ff.pull_low;
   assign rsp_if.busy_res        = rsp_data_ff.busy_res;
   assign rsp_if.accepted        = rsp_data_ff.accepted;
   assign rsp_if.done_res        = rsp_data_ff.done_res;
   assign rsp_if.present         = rsp_data_ff.present;
   assign rsp_if.read_byte       = rsp_data_ff.read_byte;
   assign rsp_if.temperature_raw = rsp_data_ff.temperature_raw;

   // A finishing tick leaves the bus idle and released.
   a_done_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.done_res |-> !rsp_data_ff.busy_res && !rsp_data_ff.pull_low)
      else $error("operation finished but bus still busy or driven");

   // An idle master never drives the line.
   a_idle_release : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.busy_res |-> !rsp_data_ff.pull_low)
      else $error("line pulled low while idle");

   // A taken command always starts an operation.
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.accepted |-> rsp_data_ff.busy_res && !rsp_data_ff.done_res)
      else $error("accepted command did not start an operation");

   // Every request transfer produces a result in the next cycle.
   a_result_follows : assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid_ff)
      else $error("request transfer produced no result");

endmodule

`default_nettype wire

### test/owm_result_checker.sv
// Result checker for the single-wire bus master: mirrors the bus timing and
// sequence behaviour per transfer and compares every result field.
// Depends on owm_pkg and the channel interfaces in owm_if.
module owm_result_checker import owm_pkg::*; (
   input  logic clock,
   input  logic reset,
   owm_req_if   req,
   owm_rsp_if   rsp,
   owm_csr_if   csr,
   output int   failures
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned TICK_MAX = (1 << TIMER_WIDTH_DEF) - 1;
   localparam int REPORT_LIMIT = 10;

   logic [CFG_W-1:0] timing [CFG_COUNT];
   phase_type        bus_phase;
   int unsigned      slot_left;
   logic [2:0]       bit_pos;
   logic [2:0]       seq_step;
   logic [2:0]       active_cmd;
   logic [7:0]       shifter;
   logic [7:0]       last_rx;
   logic [15:0]      temp_word;
   logic             presence_seen;

   result_type       master_results_due [$];
   int unsigned      mismatch_count;
   int unsigned      result_number;

   function automatic void enter_phase(phase_type ph, logic [CFG_W-1:0] us);
      int unsigned t;
      t = us;
      if (t < 1) t = 1;
      if (t > TICK_MAX) t = TICK_MAX;
      bus_phase = ph;
      slot_left = t;
   endfunction

   function automatic void start_byte_write(logic [7:0] b);
      shifter = b;
      bit_pos = '0;
      enter_phase(PH_WR_START, timing[REG_SLOT_START]);
   endfunction

   function automatic void start_byte_read();
      shifter = '0;
      bit_pos = '0;
      enter_phase(PH_RD_START, timing[REG_SLOT_START]);
   endfunction

   // A reset or a byte has completed: move on within the sequence or stop.
   function automatic logic finish_element();
      seq_step = seq_step + 3'd1;
      if (active_cmd == OP_CONVERT) begin
         if (seq_step == STEP_FIRST_BYTE && presence_seen) begin
            start_byte_write(CMD_SKIP_ROM);
            return 1'b0;
         end
         if (seq_step == STEP_SECOND_BYTE) begin
            start_byte_write(CMD_CONVERT);
            return 1'b0;
         end
      end else if (active_cmd == OP_READ_TEMP) begin
         if (seq_step == STEP_FIRST_BYTE) begin
            if (presence_seen) begin
               start_byte_write(CMD_SKIP_ROM);
               return 1'b0;
            end
            temp_word = '0;
         end else if (seq_step == STEP_SECOND_BYTE) begin
            start_byte_write(CMD_READ_SCRATCH);
            return 1'b0;
         end else if (seq_step == STEP_LOW_BYTE || seq_step == STEP_HIGH_BYTE) begin
            start_byte_read();
            return 1'b0;
         end
      end
      bus_phase = PH_IDLE;
      slot_left = 0;
      return 1'b1;
   endfunction

   function automatic logic advance_microsecond(logic line);
      if (bus_phase == PH_IDLE) return 1'b0;
      if (slot_left > 1) begin
         slot_left--;
         return 1'b0;
      end
      case (bus_phase)
         PH_RST_LOW: enter_phase(PH_RST_WAIT, timing[REG_PRESENCE_WAIT]);
         PH_RST_WAIT: begin
            presence_seen = !line;
            enter_phase(PH_RST_TAIL, timing[REG_RESET_TAIL]);
         end
         PH_RST_TAIL: return finish_element();
         PH_WR_START: enter_phase(PH_WR_HOLD, timing[REG_WRITE_HOLD]);
         PH_WR_HOLD: enter_phase(PH_WR_REC, timing[REG_WRITE_REC]);
         PH_WR_REC: begin
            shifter = shifter >> 1;
            if (bit_pos == LAST_BIT) return finish_element();
            bit_pos++;
            enter_phase(PH_WR_START, timing[REG_SLOT_START]);
         end
         PH_RD_START: enter_phase(PH_RD_WAIT, timing[REG_READ_SAMPLE]);
         PH_RD_WAIT: begin
            shifter = {line, shifter[7:1]};
            enter_phase(PH_RD_REC, timing[REG_READ_REC]);
         end
         PH_RD_REC: begin
            if (bit_pos == LAST_BIT) begin
               // The high byte completes the word; the low byte is the previous one.
               if (active_cmd == OP_READ_TEMP && seq_step == STEP_HIGH_BYTE)
                  temp_word = {shifter, last_rx};
               last_rx = shifter;
               return finish_element();
            end
            bit_pos++;
            enter_phase(PH_RD_START, timing[REG_SLOT_START]);
         end
         default: begin
            bus_phase = PH_IDLE;
            slot_left = 0;
         end
      endcase
      return 1'b0;
   endfunction

   function automatic result_type step_bus_master(logic [2:0] op, logic [7:0] wb, logic line);
      result_type r;
      logic took;
      logic fin;
      took = 1'b0;
      fin  = 1'b0;
      if (op == OP_TICK) begin
         fin = advance_microsecond(line);
      end else if (op <= OP_READ_TEMP && bus_phase == PH_IDLE) begin
         took = 1'b1;
         active_cmd = op;
         seq_step = '0;
         if (op == OP_WRITE) start_byte_write(wb);
         else if (op == OP_READ) start_byte_read();
         else enter_phase(PH_RST_LOW, timing[REG_RESET_LOW]);
      end
      r.pull_low = (bus_phase == PH_RST_LOW || bus_phase == PH_WR_START ||
                    bus_phase == PH_RD_START) ||
                   (bus_phase == PH_WR_HOLD && !shifter[0]);
      r.busy_res        = (bus_phase != PH_IDLE);
      r.accepted        = took;
      r.done_res        = fin;
      r.present         = presence_seen;
      r.read_byte       = last_rx;
      r.temperature_raw = temp_word;
      return r;
   endfunction

   function automatic void flag_mismatch(string what, logic [15:0] want, logic [15:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("ERROR at %0t: result %0d, %s expected 0x%0h, got 0x%0h",
                  $realtime, result_number, what, want, got);
   endfunction

   function automatic void compare_field(string what, logic [15:0] want, logic [15:0] got);
      if (want !== got) flag_mismatch(what, want, got);
   endfunction

   always @(posedge clock) begin : monitor
      result_type want;
      if (reset) begin
         timing[REG_RESET_LOW]     = RST_RESET_LOW;
         timing[REG_PRESENCE_WAIT] = RST_PRESENCE_WAIT;
         timing[REG_RESET_TAIL]    = RST_RESET_TAIL;
         timing[REG_SLOT_START]    = RST_SLOT_START;
         timing[REG_WRITE_HOLD]    = RST_WRITE_HOLD;
         timing[REG_WRITE_REC]     = RST_WRITE_REC;
         timing[REG_READ_SAMPLE]   = RST_READ_SAMPLE;
         timing[REG_READ_REC]      = RST_READ_REC;
         bus_phase     = PH_IDLE;
         slot_left     = 0;
         bit_pos       = '0;
         seq_step      = '0;
         active_cmd    = '0;
         shifter       = '0;
         last_rx       = '0;
         temp_word     = '0;
         presence_seen = 1'b0;
         master_results_due.delete();
         mismatch_count = 0;
         result_number  = 0;
         failures <= 0;
      end else begin
         if (csr.valid && csr.ready) timing[csr.index] = csr.data;
         if (req.valid && req.ready)
            master_results_due.push_back(step_bus_master(req.op, req.write_byte,
                                                         req.line_level));
         if (rsp.valid && rsp.ready) begin
            if (master_results_due.size() == 0) begin
               flag_mismatch("unrequested transfer, busy_res", 16'h0, 16'(rsp.busy_res));
            end else begin
               want = master_results_due.pop_front();
               compare_field("pull_low", 16'(want.pull_low), 16'(rsp.pull_low));
               compare_field("busy_res", 16'(want.busy_res), 16'(rsp.busy_res));
               compare_field("accepted", 16'(want.accepted), 16'(rsp.accepted));
               compare_field("done_res", 16'(want.done_res), 16'(rsp.done_res));
               compare_field("present", 16'(want.present), 16'(rsp.present));
               compare_field("read_byte", 16'(want.read_byte), 16'(rsp.read_byte));
               compare_field("temperature_raw", want.temperature_raw, rsp.temperature_raw);
            end
            result_number++;
         end
         // Results still owed count against the run until they arrive.
         failures <= mismatch_count + master_results_due.size();
      end
   end

endmodule

### test/one_wire_master_temp_reader_top_tb.sv
// Top of the single-wire bus master testbench: clock, reset, stimulus,
// timing register settings and the final verdict. Depends on owm_pkg,
// owm_if, the block one_wire_master_temp_reader_top and owm_result_checker.
module one_wire_master_temp_reader_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import owm_pkg::*;

   // Opcodes that the block must ignore.
   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   localparam int unsigned QUIET_LIMIT = 4000;
   localparam int unsigned LONG_HOLD   = 80;
   localparam int unsigned TICK_CAP    = 5000;
   localparam int unsigned PHASE_ITEMS = 60;
   localparam int unsigned PHASES      = 5;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int          failures;
   int unsigned sent_count = 0;
   int unsigned received_count = 0;
   int unsigned done_count = 0;
   int unsigned quiet_cycles = 0;
   logic        last_busy = 1'b0;
   logic        calm = 1'b0;
   int unsigned hold_asks = 0;
   logic [CFG_W-1:0] setting [CFG_COUNT];

   owm_req_if req_if ();
   owm_rsp_if rsp_if ();
   owm_csr_if csr_if ();

   one_wire_master_temp_reader_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   owm_result_checker u_checker (
      .clock    (clock),
      .reset    (reset),
      .req      (req_if),
      .rsp      (rsp_if),
      .csr      (csr_if),
      .failures (failures)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Transfer counters and the watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (reset) begin
         sent_count     <= 0;
         received_count <= 0;
         done_count     <= 0;
         last_busy      <= 1'b0;
         quiet_cycles   <= 0;
      end else begin
         if (req_if.valid && req_if.ready) sent_count <= sent_count + 1;
         if (rsp_if.valid && rsp_if.ready) begin
            received_count <= received_count + 1;
            done_count     <= done_count + rsp_if.done_res;
            last_busy      <= rsp_if.busy_res;
         end
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Result receiver: random stalls, long hold-offs on request, none when calm.
   initial begin : receiver
      int unsigned holds_served;
      holds_served = 0;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_asks != holds_served) begin
            holds_served++;
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!calm && $urandom_range(0, 99) < 35) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   end

   function automatic int unsigned effective_us(logic [CFG_W-1:0] v);
      return (v == 0) ? 1 : v;
   endfunction

   // Ticks from a reset command up to and including its presence sample.
   function automatic int unsigned presence_lead();
      return effective_us(setting[REG_RESET_LOW]) + effective_us(setting[REG_PRESENCE_WAIT]);
   endfunction

   // The line is held low for the first lead ticks, then low with low_pct odds.
   function automatic logic line_for(int unsigned n, int unsigned lead, int unsigned low_pct);
      if (n < lead) return 1'b0;
      return ($urandom_range(0, 99) >= low_pct);
   endfunction

   task automatic push_item(logic [2:0] op, logic [7:0] wb, logic line);
      if (!calm && $urandom_range(0, 99) < 8) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.op         <= op;
      req_if.write_byte <= wb;
      req_if.line_level <= line;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (received_count < sent_count) @(posedge clock);
   endtask

   // Bring the block to rest: every result in and the bus no longer busy.
   task automatic settle();
      int unsigned n;
      n = 0;
      drain();
      while (last_busy && n < TICK_CAP) begin
         push_item(OP_TICK, 8'($urandom), 1'b1);
         drain();
         n++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic load_timings();
      int i;
      settle();
      for (i = 0; i < CFG_COUNT; i++) begin
         csr_if.valid <= 1'b1;
         csr_if.index <= CFG_IDX_W'(i);
         csr_if.data  <= setting[i];
         do @(posedge clock); while (!csr_if.ready);
      end
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic choose_timings(logic [CFG_W-1:0] reset_us, logic [CFG_W-1:0] slot_us);
      setting[REG_RESET_LOW]     = reset_us;
      setting[REG_PRESENCE_WAIT] = reset_us;
      setting[REG_RESET_TAIL]    = reset_us;
      setting[REG_SLOT_START]    = slot_us;
      setting[REG_WRITE_HOLD]    = slot_us;
      setting[REG_WRITE_REC]     = slot_us;
      setting[REG_READ_SAMPLE]   = slot_us;
      setting[REG_READ_REC]      = slot_us;
      load_timings();
   endtask

   // Keeps ticking until an operation reports completion; stray commands are
   // mixed in when noisy, and those arriving while busy must be refused.
   task automatic ticks_until_done(int unsigned d0, int unsigned lead,
                                   int unsigned low_pct, bit noisy);
      int unsigned n;
      n = 0;
      while (done_count == d0 && n < TICK_CAP) begin
         if (noisy && $urandom_range(0, 99) < 3) begin
            push_item(3'($urandom_range(OP_BUS_RESET, OP_SPARE_HI)), 8'($urandom),
                      1'($urandom));
         end else begin
            push_item(OP_TICK, 8'($urandom), line_for(n, lead, low_pct));
            n++;
         end
      end
   endtask

   task automatic run_command(logic [2:0] op, logic [7:0] wb, int unsigned lead,
                              int unsigned low_pct, bit noisy);
      int unsigned d0;
      d0 = done_count;
      push_item(op, wb, 1'($urandom));
      ticks_until_done(d0, lead, low_pct, noisy);
   endtask

   initial begin : stimulus
      int unsigned d0;
      int unsigned phase_start;
      int unsigned pick;
      int unsigned lead;
      int unsigned low_pct;
      int unsigned commands;
      logic [2:0]  op;
      req_if.valid      <= 1'b0;
      req_if.op         <= OP_TICK;
      req_if.write_byte <= 8'h00;
      req_if.line_level <= 1'b1;
      csr_if.valid      <= 1'b0;
      csr_if.index      <= REG_RESET_LOW;
      csr_if.data       <= '0;
      setting[REG_RESET_LOW]     = RST_RESET_LOW;
      setting[REG_PRESENCE_WAIT] = RST_PRESENCE_WAIT;
      setting[REG_RESET_TAIL]    = RST_RESET_TAIL;
      setting[REG_SLOT_START]    = RST_SLOT_START;
      setting[REG_WRITE_HOLD]    = RST_WRITE_HOLD;
      setting[REG_WRITE_REC]     = RST_WRITE_REC;
      setting[REG_READ_SAMPLE]   = RST_READ_SAMPLE;
      setting[REG_READ_REC]      = RST_READ_REC;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Idle ticks and unused opcodes change nothing.
      push_item(OP_TICK, 8'hFF, 1'b0);
      push_item(OP_TICK, 8'h00, 1'b1);
      push_item(OP_SPARE_LO, 8'h5A, 1'b0);
      push_item(OP_SPARE_HI, 8'hA5, 1'b1);

      // Zero in every register behaves as one microsecond.
      choose_timings('0, '0);
      run_command(OP_BUS_RESET, 8'h00, 0, 100, 1'b0);
      run_command(OP_WRITE, 8'h00, 0, 50, 1'b0);
      run_command(OP_WRITE, 8'hFF, 0, 50, 1'b0);
      run_command(OP_READ, 8'h00, 0, 0, 1'b0);
      run_command(OP_READ, 8'hFF, 0, 100, 1'b0);
      run_command(OP_CONVERT, 8'h00, presence_lead(), 50, 1'b0);
      run_command(OP_CONVERT, 8'h00, 0, 0, 1'b0);
      run_command(OP_READ_TEMP, 8'h00, presence_lead(), 0, 1'b0);
      run_command(OP_READ_TEMP, 8'h00, presence_lead(), 100, 1'b0);
      run_command(OP_READ_TEMP, 8'h00, 0, 0, 1'b0);

      // The first command starts a read; those offered while it runs are refused.
      d0 = done_count;
      push_item(OP_READ, 8'h00, 1'b1);
      push_item(OP_WRITE, 8'h3C, 1'b1);
      push_item(OP_READ_TEMP, 8'h00, 1'b0);
      push_item(OP_SPARE_HI, 8'h00, 1'b0);
      // The sender waits for every outstanding result.
      drain();
      ticks_until_done(d0, 0, 50, 1'b0);

      // Long reset timings, shortest slots.
      choose_timings(10'd30, 10'd1);
      run_command(OP_BUS_RESET, 8'h00, presence_lead(), 0, 1'b0);
      run_command(OP_CONVERT, 8'h00, 0, 0, 1'b0);

      // Long slot timings, shortest reset.
      choose_timings(10'd1, 10'd6);
      run_command(OP_WRITE, 8'hA5, 0, 50, 1'b0);
      run_command(OP_READ, 8'h00, 0, 50, 1'b0);

      // Random phases with short timings; the last one runs without idling.
      for (int p = 0; p < PHASES; p++) begin
         foreach (setting[i]) setting[i] = CFG_W'($urandom_range(0, 2));
         if ($urandom_range(0, 3) == 0)
            setting[$urandom_range(0, CFG_COUNT - 1)] = CFG_W'($urandom_range(3, 12));
         load_timings();
         calm <= (p == PHASES - 1);
         @(posedge clock);
         phase_start = sent_count;
         commands = 0;
         while (sent_count - phase_start < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)      op = OP_READ_TEMP;
            else if (pick < 60) op = OP_CONVERT;
            else if (pick < 73) op = OP_WRITE;
            else if (pick < 86) op = OP_READ;
            else                op = OP_BUS_RESET;
            lead = ($urandom_range(0, 99) < 75) ? presence_lead() : $urandom_range(0, 3);
            case ($urandom_range(0, 4))
               0:       low_pct = 0;
               1:       low_pct = 30;
               2:       low_pct = 50;
               3:       low_pct = 70;
               default: low_pct = 100;
            endcase
            // The receiver holds off while items keep coming, filling the block.
            if (p == 1 && commands == 0) hold_asks <= hold_asks + 1;
            run_command(op, 8'($urandom), lead, low_pct, 1'b1);
            commands++;
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
